// ===== rtl/msv_pkg.sv =====
// Shared types and constants of the manifest stream validator.
package msv_pkg;

  localparam int unsigned HeaderBytes      = 16;
  localparam int unsigned EntryHeaderBytes = 12;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SMALL       = 3'd1,
    ST_MAGIC       = 3'd2,
    ST_VERSION     = 3'd3,
    ST_ENTRY_TRUNC = 3'd4,
    ST_UNSORTED    = 3'd5,
    ST_PATH_TRUNC  = 3'd6,
    ST_TRAILING    = 3'd7
  } status_t;

  typedef enum logic [0:0] {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] entry_index;
  } verdict_t;

endpackage

// ===== rtl/msv_byte_if.sv =====
// Stream channel that carries one manifest byte and its end marker per beat.
interface msv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/msv_verdict_if.sv =====
// Stream channel that carries one verdict per manifest stream.
interface msv_verdict_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_index;

  modport source (output valid, output status, output entry_index, input ready);
  modport sink (input valid, input status, input entry_index, output ready);
endinterface

// ===== rtl/manifest_stream_validator_core.sv =====
// Top level of the manifest stream validator: configuration, parser and verdict register.
// The verdict is registered and becomes valid in the cycle after the beat marked last is accepted.
// Throughput: one byte beat per cycle; input stalls only while a verdict waits unaccepted.
// The parser updates its state in the accepting cycle; the verdict register decouples the sides.
// Reset (synchronous, rst_n low) clears the parser, the verdict register and both registers.
module manifest_stream_validator_core
  import msv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  msv_byte_if.sink      in_byte,
  msv_verdict_if.source out_verdict,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  logic [31:0] magic_r;
  logic [31:0] version_r;
  logic        out_valid_r;
  verdict_t    verdict_r;
  verdict_t    verdict;
  logic        in_acc;

  assign in_byte.ready = !out_valid_r || out_verdict.ready;
  assign in_acc        = in_byte.valid && in_byte.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAGIC:   magic_r <= cfg_wdata;
        REG_VERSION: version_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  msv_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .data_byte   (in_byte.data_byte),
    .last_byte   (in_byte.last_byte),
    .cfg_magic   (magic_r),
    .cfg_version (version_r),
    .verdict     (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_byte.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_verdict.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verdict_r <= '0;
    end else if (in_acc && in_byte.last_byte) begin
      verdict_r <= verdict;
    end
  end

  assign out_verdict.valid       = out_valid_r;
  assign out_verdict.status      = verdict_r.status;
  assign out_verdict.entry_index = verdict_r.entry_index;

endmodule

// ===== rtl/msv_parse.sv =====
// Byte-by-byte manifest parser state with the verdict for the current beat.
module msv_parse
  import msv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] cfg_magic,
  input  logic [31:0] cfg_version,
  output verdict_t    verdict
);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_ENTRY  = 5'b00010,
    PH_PATH   = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] word_r, word_nxt;
  logic [63:0] prev_hash_r, prev_hash_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] number_r, number_nxt;
  logic [15:0] path_left_r, path_left_nxt;
  status_t     err_r, err_nxt;
  phase_t      phase_new;
  status_t     err_new;
  logic [31:0] number_new;
  logic [31:0] number_inc;
  logic [15:0] path_dec;

  assign number_inc = number_r + 32'd1;
  assign path_dec   = path_left_r - 16'd1;

  always_comb begin
    phase_new     = phase_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    prev_hash_nxt = prev_hash_r;
    total_nxt     = total_r;
    number_new    = number_r;
    path_left_nxt = path_left_r;
    err_new       = err_r;
    case (phase_r)
      PH_HEADER: begin
        if (pos_r[3] == 1'b0) begin
          word_nxt[{pos_r[2:0], 3'b000} +: 8] = data_byte;
        end else if (pos_r[2] == 1'b0) begin
          total_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
        end
        if (pos_r != 4'(HeaderBytes - 1)) begin
          pos_nxt = pos_r + 4'd1;
        end else begin
          pos_nxt = '0;
          if (word_r[31:0] != cfg_magic) begin
            err_new   = ST_MAGIC;
            phase_new = PH_ERROR;
          end else if (word_r[63:32] != cfg_version) begin
            err_new   = ST_VERSION;
            phase_new = PH_ERROR;
          end else begin
            word_nxt  = '0;
            phase_new = (total_r == '0) ? PH_DONE : PH_ENTRY;
          end
        end
      end
      PH_ENTRY: begin
        if (pos_r == 4'd0) begin
          word_nxt      = '0;
          path_left_nxt = '0;
        end
        if (pos_r[3] == 1'b0) begin
          word_nxt[{pos_r[2:0], 3'b000} +: 8] = data_byte;
        end else if (pos_r == 4'd10) begin
          path_left_nxt[7:0] = data_byte;
        end else if (pos_r == 4'd11) begin
          path_left_nxt[15:8] = data_byte;
        end
        if (pos_r != 4'(EntryHeaderBytes - 1)) begin
          pos_nxt = pos_r + 4'd1;
        end else begin
          pos_nxt = '0;
          if ((number_r != '0) && (word_r < prev_hash_r)) begin
            err_new   = ST_UNSORTED;
            phase_new = PH_ERROR;
          end else begin
            prev_hash_nxt = word_r;
            if (path_left_nxt == '0) begin
              number_new = number_inc;
              phase_new  = (number_inc == total_r) ? PH_DONE : PH_ENTRY;
            end else begin
              phase_new = PH_PATH;
            end
          end
        end
      end
      PH_PATH: begin
        path_left_nxt = path_dec;
        if (path_dec == '0) begin
          number_new = number_inc;
          pos_nxt    = '0;
          phase_new  = (number_inc == total_r) ? PH_DONE : PH_ENTRY;
        end
      end
      PH_DONE: begin
        err_new   = ST_TRAILING;
        phase_new = PH_ERROR;
      end
      default: begin
      end
    endcase

    case (phase_new)
      PH_ERROR:  verdict.status = err_new;
      PH_HEADER: verdict.status = ST_SMALL;
      PH_ENTRY:  verdict.status = ST_ENTRY_TRUNC;
      PH_PATH:   verdict.status = ST_PATH_TRUNC;
      default:   verdict.status = ST_OK;
    endcase
    verdict.entry_index = number_new;

    phase_nxt  = phase_new;
    err_nxt    = err_new;
    number_nxt = number_new;
    if (last_byte) begin
      phase_nxt     = PH_HEADER;
      pos_nxt       = '0;
      word_nxt      = '0;
      prev_hash_nxt = '0;
      total_nxt     = '0;
      number_nxt    = '0;
      path_left_nxt = '0;
      err_nxt       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      word_r      <= '0;
      prev_hash_r <= '0;
      total_r     <= '0;
      number_r    <= '0;
      path_left_r <= '0;
      err_r       <= ST_OK;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      word_r      <= word_nxt;
      prev_hash_r <= prev_hash_nxt;
      total_r     <= total_nxt;
      number_r    <= number_nxt;
      path_left_r <= path_left_nxt;
      err_r       <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_path_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PATH) |-> (path_left_r != '0))
    else $error("path phase with no path bytes left");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (number_r == total_r))
    else $error("done phase before all entries were read");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR) |-> (err_r != ST_OK) && (err_r != ST_SMALL))
    else $error("error phase without a latched error code");

  a_entry_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENTRY) |-> (pos_r < 4'(EntryHeaderBytes)))
    else $error("entry header position out of range");
`endif

endmodule

// ===== sim/manifest_stream_validator_core_tb.sv =====
// Self-checking testbench for the manifest stream validator: random and directed streams.
module manifest_stream_validator_core_tb
  import msv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeatsPerPhase = 120;
  localparam int HoldCycles          = 300;

  typedef enum logic [2:0] {
    PARSE_HEADER,
    PARSE_ENTRY,
    PARSE_PATH,
    PARSE_DONE,
    PARSE_ERROR
  } parse_phase_e;

  typedef enum {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_COUNT,
    FLAW_UNSORTED,
    FLAW_TRAILING,
    FLAW_CUT
  } flaw_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;

  msv_byte_if    in_byte_ch ();
  msv_verdict_if verdict_ch ();

  manifest_stream_validator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_byte_ch),
    .out_verdict(verdict_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  logic [31:0] cfg_magic;
  logic [31:0] cfg_version;

  parse_phase_e parse_phase;
  int unsigned  field_pos;
  logic [63:0]  word_acc;
  logic [63:0]  last_hash;
  logic [31:0]  count_declared;
  logic [31:0]  entries_seen;
  logic [15:0]  path_remaining;
  status_t      first_error;

  verdict_t    verdicts_due[$];
  beat_t       pending_beats[$];
  logic [7:0]  draft[$];
  beat_t       offer;
  verdict_t    got;
  verdict_t    want;

  int beats_queued;
  int beats_taken;
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_tickets;
  int hold_served;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic reset_parse();
    parse_phase    = PARSE_HEADER;
    field_pos      = 0;
    word_acc       = '0;
    last_hash      = '0;
    count_declared = '0;
    entries_seen   = '0;
    path_remaining = '0;
    first_error    = ST_OK;
  endtask

  task automatic flag_error(input status_t code);
    first_error = code;
    parse_phase = PARSE_ERROR;
  endtask

  task automatic advance_entry();
    entries_seen = entries_seen + 1;
    field_pos    = 0;
    parse_phase  = (entries_seen == count_declared) ? PARSE_DONE : PARSE_ENTRY;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    verdict_t v;
    case (parse_phase)
      PARSE_HEADER: begin
        if (field_pos < 8) begin
          word_acc[8*field_pos +: 8] = b;
        end else if (field_pos < 12) begin
          count_declared[8*(field_pos-8) +: 8] = b;
        end
        if (field_pos + 1 < HeaderBytes) begin
          field_pos = field_pos + 1;
        end else begin
          field_pos = 0;
          if (word_acc[31:0] != cfg_magic) begin
            flag_error(ST_MAGIC);
          end else if (word_acc[63:32] != cfg_version) begin
            flag_error(ST_VERSION);
          end else begin
            word_acc    = '0;
            parse_phase = (count_declared == 0) ? PARSE_DONE : PARSE_ENTRY;
          end
        end
      end
      PARSE_ENTRY: begin
        if (field_pos == 0) begin
          word_acc       = '0;
          path_remaining = '0;
        end
        if (field_pos < 8) begin
          word_acc[8*field_pos +: 8] = b;
        end else if (field_pos >= 10 && field_pos < 12) begin
          path_remaining[8*(field_pos-10) +: 8] = b;
        end
        if (field_pos + 1 < EntryHeaderBytes) begin
          field_pos = field_pos + 1;
        end else begin
          field_pos = 0;
          if (entries_seen > 0 && word_acc < last_hash) begin
            flag_error(ST_UNSORTED);
          end else begin
            last_hash = word_acc;
            if (path_remaining == 0) begin
              advance_entry();
            end else begin
              parse_phase = PARSE_PATH;
            end
          end
        end
      end
      PARSE_PATH: begin
        path_remaining = path_remaining - 16'd1;
        if (path_remaining == 0) begin
          advance_entry();
        end
      end
      PARSE_DONE: begin
        flag_error(ST_TRAILING);
      end
      default: begin
      end
    endcase
    if (is_last) begin
      case (parse_phase)
        PARSE_ERROR:  v.status = first_error;
        PARSE_HEADER: v.status = ST_SMALL;
        PARSE_ENTRY:  v.status = ST_ENTRY_TRUNC;
        PARSE_PATH:   v.status = ST_PATH_TRUNC;
        default:      v.status = ST_OK;
      endcase
      v.entry_index = entries_seen;
      verdicts_due = {verdicts_due, v};
      reset_parse();
    end
  endtask

  task automatic add_le(input logic [63:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      draft = {draft, value[8*i +: 8]};
    end
  endtask

  task automatic add_header(input logic [31:0] magic, input logic [31:0] version,
                            input logic [31:0] count);
    add_le(magic, 4);
    add_le(version, 4);
    add_le(count, 4);
    add_le($urandom, 4);
  endtask

  task automatic add_entry(input logic [63:0] hash, input logic [15:0] plen, input int emit);
    add_le(hash, 8);
    add_le($urandom, 2);
    add_le(plen, 2);
    for (int i = 0; i < emit; i++) begin
      add_le($urandom, 1);
    end
  endtask

  task automatic ship();
    beat_t b;
    for (int i = 0; i < draft.size(); i++) begin
      b.data_byte = draft[i];
      b.last_byte = (i == draft.size() - 1);
      pending_beats = {pending_beats, b};
    end
    beats_queued = beats_queued + draft.size();
    draft.delete();
  endtask

  task automatic random_stream();
    int          style;
    int          n;
    int          bad_at;
    int          keep;
    int          r;
    flaw_e       flaw;
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] declared;
    logic [63:0] h;
    logic [63:0] bump;
    logic [15:0] plen;
    style = $urandom_range(0, 99);
    if (style < 12) begin
      add_le($urandom, 1);
      repeat ($urandom_range(0, $urandom_range(0, 1) ? 14 : 39)) add_le($urandom, 1);
      ship();
    end else begin
      n       = $urandom_range(0, 5);
      flaw    = ($urandom_range(0, 99) < 55) ? FLAW_NONE : flaw_e'($urandom_range(1, 6));
      magic   = cfg_magic;
      version = cfg_version;
      if (flaw == FLAW_UNSORTED && n < 2) begin
        n = $urandom_range(2, 5);
      end
      bad_at   = (n >= 2) ? $urandom_range(1, n - 1) : 0;
      declared = n;
      case (flaw)
        FLAW_MAGIC:   magic = magic ^ (32'd1 << $urandom_range(0, 31));
        FLAW_VERSION: version = version ^ (32'd1 << $urandom_range(0, 31));
        FLAW_COUNT: begin
          case ($urandom_range(0, 3))
            0:       declared = n + 1;
            1:       declared = n + 2;
            2:       declared = (n > 0) ? n - 1 : 1;
            default: declared = {1'b1, 31'($urandom)};
          endcase
        end
        default: begin
        end
      endcase
      add_header(magic, version, declared);
      h = {$urandom, $urandom} >> $urandom_range(0, 63);
      for (int i = 0; i < n; i++) begin
        if (i > 0) begin
          bump = {$urandom, $urandom} >> $urandom_range(1, 63);
          if (flaw == FLAW_UNSORTED && i == bad_at && h != 0) begin
            h = h - 1 - (bump % h);
          end else if ($urandom_range(0, 3) != 0) begin
            h = h + ({$urandom, $urandom} >> $urandom_range(4, 63));
          end
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
          plen = 16'($urandom_range(0, 5));
        end else if (r < 99) begin
          plen = 16'($urandom_range(6, 40));
        end else if ($urandom_range(0, 1) == 1) begin
          plen = 16'h0100 + 16'($urandom_range(0, 63));
        end else begin
          plen = 16'hFFFF;
        end
        if (plen == 16'hFFFF) begin
          add_entry(h, plen, $urandom_range(200, 400));
          break;
        end
        add_entry(h, plen, plen);
      end
      if (flaw == FLAW_TRAILING) begin
        repeat ($urandom_range(1, 4)) add_le($urandom, 1);
      end
      if (flaw == FLAW_CUT) begin
        keep = $urandom_range(1, draft.size() - 1);
        while (draft.size() > keep) void'(draft.pop_back());
      end
      ship();
    end
  endtask

  task automatic set_limits(input logic [31:0] magic, input logic [31:0] version);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= REG_VERSION;
    cfg_wdata <= version;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_magic   = magic;
    cfg_version = version;
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = beats_queued;
    while (beats_queued - start < RandomBeatsPerPhase) random_stream();
    while (beats_taken != beats_queued || verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The driver only replaces a beat once it has been taken or was never offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_byte_ch.valid <= 1'b0;
    end else if (!in_byte_ch.valid || in_byte_ch.ready) begin
      if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offer = pending_beats.pop_front();
        in_byte_ch.valid     <= 1'b1;
        in_byte_ch.data_byte <= offer.data_byte;
        in_byte_ch.last_byte <= offer.last_byte;
      end else begin
        in_byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      verdict_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      verdict_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_tickets) begin
      verdict_ch.ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HoldCycles;
    end else begin
      verdict_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_byte_ch.valid && in_byte_ch.ready) begin
        absorb_byte(in_byte_ch.data_byte, in_byte_ch.last_byte);
        beats_taken = beats_taken + 1;
      end
      if (verdict_ch.valid && verdict_ch.ready) begin
        got.status      = status_t'(verdict_ch.status);
        got.entry_index = verdict_ch.entry_index;
        if (verdicts_due.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected verdict: expected none, actual status %0d index %0d",
                   $time, got.status, got.entry_index);
        end else begin
          want = verdicts_due.pop_front();
          if (got.status !== want.status || got.entry_index !== want.entry_index) begin
            mismatches = mismatches + 1;
            $display("%0t: verdict mismatch: expected status %0d index %0d, actual %0d %0d",
                     $time, want.status, want.entry_index, got.status, got.entry_index);
          end
        end
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_MAGIC;
    cfg_wdata            = '0;
    in_byte_ch.valid     = 1'b0;
    in_byte_ch.data_byte = '0;
    in_byte_ch.last_byte = 1'b0;
    verdict_ch.ready     = 1'b0;
    cfg_magic            = '0;
    cfg_version          = '0;
    beats_queued         = 0;
    beats_taken          = 0;
    mismatches           = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_tickets         = 0;
    hold_served          = 0;
    hold_left            = 0;
    reset_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_limits($urandom, $urandom);
    add_le($urandom, 1);
    ship();
    add_le({$urandom, $urandom}, 8);
    add_le({$urandom, $urandom}, 7);
    ship();
    add_header(cfg_magic ^ 32'h8000_0000, cfg_version, 0);
    ship();
    add_header(cfg_magic, cfg_version ^ 32'h1, 0);
    ship();
    add_header(~cfg_magic, ~cfg_version, 0);
    ship();
    add_header(cfg_magic, cfg_version, 0);
    ship();
    add_header(cfg_magic, cfg_version, 0);
    add_le($urandom, 1);
    ship();
    add_header(cfg_magic, cfg_version, 1);
    add_entry(64'h0, 0, 0);
    ship();
    // The second hash is lower; the bytes after it must not change the verdict.
    add_header(cfg_magic, cfg_version, 2);
    add_entry(64'h8000_0000_0000_0000, 1, 1);
    add_entry(64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
    add_le($urandom, 3);
    ship();
    add_header(cfg_magic, cfg_version, 3);
    repeat (3) add_entry('1, 3, 3);
    ship();
    add_header(cfg_magic, cfg_version, 1);
    add_le({$urandom, $urandom}, 5);
    ship();
    add_header(cfg_magic, cfg_version, 1);
    add_entry(64'h1234, 4, 2);
    ship();
    add_header(cfg_magic, cfg_version, 1);
    add_entry(64'h1234, 0, 0);
    add_le($urandom, 2);
    ship();
    add_header(cfg_magic, cfg_version, 32'hFFFF_FFFF);
    add_entry(64'h1, 0, 0);
    ship();
    add_header(cfg_magic, cfg_version, 1);
    add_entry(64'h5, 16'h0100, 256);
    ship();
    add_header(cfg_magic, cfg_version, 2);
    add_entry(64'h7, 16'hFFFF, 300);
    ship();
    run_random_phase(0, 0);

    set_limits(32'h0000_0000, 32'h0000_0000);
    run_random_phase(54, 0);

    // One-beat streams keep the sender busy while the receiver holds off.
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_tickets = hold_tickets + 1;
    repeat (40) begin
      add_le($urandom, 1);
      ship();
    end
    run_random_phase(0, 54);

    set_limits($urandom, $urandom);
    run_random_phase(34, 34);

    set_limits(32'hFFFF_FFFF, 32'h0000_0000);
    run_random_phase(0, 0);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== manifest_stream_validator_core.f =====
rtl/msv_pkg.sv
rtl/msv_byte_if.sv
rtl/msv_verdict_if.sv
rtl/msv_parse.sv
rtl/manifest_stream_validator_core.sv
sim/manifest_stream_validator_core_tb.sv
